// ===== rtl/block_refcount_allocator_defines.svh =====
// Assertion macros shared by the block reference count allocator.
`ifndef BLOCK_REFCOUNT_ALLOCATOR_DEFINES_SVH
`define BLOCK_REFCOUNT_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on clk and held off while rst_n is low.
`define BRA_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on clk and held off while rst_n is low.
`define BRA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define BRA_ASSERT_IMPLY(lbl, ante, cons, msg)
`define BRA_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== rtl/bra_pkg.sv =====
// Types and constants shared by the block reference count allocator.
package bra_pkg;

  localparam int CFG_W   = 13;  // width of the configuration registers
  localparam int BLK_W   = 12;  // width of a block number on the ports
  localparam int RC_W    = 8;   // width of a reference count
  localparam int WORD_W  = 64;  // used-map word width
  localparam int BIT_W   = 6;   // bits that select a block within a word

  localparam logic [RC_W-1:0] REF_MAX = 8'd255;

  // Request codes.
  localparam logic [1:0] REQ_ALLOC = 2'd0;
  localparam logic [1:0] REQ_GET   = 2'd1;
  localparam logic [1:0] REQ_INC   = 2'd2;
  localparam logic [1:0] REQ_FREE  = 2'd3;

  // Status codes.
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_NOFREE  = 2'd1;
  localparam logic [1:0] STAT_RANGE   = 2'd2;
  localparam logic [1:0] STAT_IGNORED = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_BLOCK_COUNT  = 2'd0;
  localparam logic [1:0] CFG_REGION_START = 2'd1;
  localparam logic [1:0] CFG_SCAN_TOP     = 2'd2;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_UPD,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [BLK_W-1:0] block_index;
  } in_item_t;

  typedef struct packed {
    logic [BLK_W-1:0] block_result;
    logic [RC_W-1:0]  ref_count;
    logic [1:0]       status;
  } out_item_t;

  // Outcome of searching one used-map word for a free block.
  typedef struct packed {
    logic             found;
    logic [BIT_W-1:0] bit_pos;
  } find_t;

endpackage

// ===== rtl/bra_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module bra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/bra_find.sv =====
// Searches one used-map word for the lowest or highest free block.
module bra_find (
  input  logic [bra_pkg::WORD_W-1:0] word,
  input  logic                       limited,
  input  logic [bra_pkg::BIT_W-1:0]  lim,
  input  logic                       from_top,
  output bra_pkg::find_t             res
);
  import bra_pkg::*;

  logic [WORD_W-1:0] free_v;

  // A block is a candidate when its bit is clear and it lies below the block count.
  always_comb begin
    for (int b = 0; b < WORD_W; b++) begin
      free_v[b] = !word[b] && (!limited || (BIT_W'(b) <= lim));
    end
  end

  always_comb begin
    res.found   = |free_v;
    res.bit_pos = '0;
    if (from_top) begin
      for (int b = 0; b < WORD_W; b++) begin
        if (free_v[b]) begin
          res.bit_pos = BIT_W'(b);
        end
      end
    end else begin
      for (int b = WORD_W - 1; b >= 0; b--) begin
        if (free_v[b]) begin
          res.bit_pos = BIT_W'(b);
        end
      end
    end
  end

endmodule

// ===== rtl/block_refcount_allocator.sv =====
// Top level of the block reference count allocator.
//
//   Channel   Direction  Handshake           Payload
//   in_       input      in_valid/in_ready   in_data   (req_type, block_index)
//   out_      output     out_valid/out_ready out_data  (block_result, ref_count, status)
//   cfg_      input      cfg_we              cfg_index, cfg_wdata
//
// After reset the block runs a clearing pass through every entry of both
// memories; in_ready stays low during it.
// Get, increment and free go through accept, memory read and result. A request
// that the range checks settle alone, or an allocate with no blocks, skips the memory read step.
// Allocate reads one 64-block used-map word per cycle, from word 0 upwards or from
// the last word downwards, and finishes at the first word that holds a free block
// or at the end of the search window.
// Items are handled one at a time; a new item is taken while the previous
// result still waits in the output register, and a held output only stalls
// the final result transfer.
module block_refcount_allocator #(
  parameter int MAX_BLOCKS = 4096  // multiple of 64, from 64 to 65536
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  bra_pkg::in_item_t        in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output bra_pkg::out_item_t       out_data,
  input  logic                     cfg_we,
  input  logic [1:0]               cfg_index,
  input  logic [bra_pkg::CFG_W-1:0] cfg_wdata
);
  import bra_pkg::*;

  localparam int WORDS = MAX_BLOCKS / WORD_W;
  localparam int BA_W  = $clog2(MAX_BLOCKS);
  localparam int WA_W  = (BA_W - BIT_W > 1) ? BA_W - BIT_W : 1;
  localparam int NW    = BA_W + 1;
  localparam int EW    = (NW > CFG_W) ? NW : CFG_W;

  // Configuration registers.
  logic [CFG_W-1:0] cfg_count_r;
  logic [CFG_W-1:0] cfg_start_r;
  logic             cfg_top_r;

  // Control and datapath registers.
  state_t           state_r, state_nxt;
  logic [BA_W-1:0]  clr_r, clr_nxt;
  logic [1:0]       req_r, req_nxt;
  logic [BA_W-1:0]  blk_r, blk_nxt;
  logic [WA_W-1:0]  wptr_r, wptr_nxt;
  logic             iss_done_r, iss_done_nxt;
  logic             chk_vld_r, chk_vld_nxt;
  logic [WA_W-1:0]  chk_ptr_r, chk_ptr_nxt;
  out_item_t        res_r, res_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;

  // Memory ports.
  logic              rc_we, um_we;
  logic [BA_W-1:0]   rc_waddr, rc_raddr;
  logic [WA_W-1:0]   um_waddr, um_raddr;
  logic [RC_W-1:0]   rc_wdata, rc_rdata;
  logic [WORD_W-1:0] um_wdata, um_rdata;

  // Derived configuration: the effective block count is clamped to MAX_BLOCKS.
  logic [EW-1:0]    bc_e, n_e, nm1_e, blk_e, start_e;
  logic             n_zero;
  logic [WA_W-1:0]  last_w, scan_end_w;
  logic [BIT_W-1:0] last_bit;

  logic       accept, out_free;
  logic       in_range, in_region;
  logic       direct;
  out_item_t  direct_res;
  find_t      fb;
  logic       scan_hit, scan_miss;
  logic [RC_W-1:0] cnt_new;

  assign bc_e     = EW'(cfg_count_r);
  assign n_e      = (bc_e > EW'(MAX_BLOCKS)) ? EW'(MAX_BLOCKS) : bc_e;
  assign n_zero   = (n_e == '0);
  assign nm1_e    = n_e - EW'(1);
  assign last_w   = WA_W'(nm1_e >> BIT_W);
  assign last_bit = nm1_e[BIT_W-1:0];
  // The word at which a search gives up: word 0 going down, the last word going up.
  assign scan_end_w = cfg_top_r ? '0 : last_w;

  assign blk_e     = EW'(in_data.block_index);
  assign start_e   = EW'(cfg_start_r);
  assign in_range  = (blk_e < n_e);
  assign in_region = in_range && (blk_e >= start_e);

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign out_free = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Configuration writes. Indexes past the register list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_count_r <= CFG_W'(4096);
      cfg_start_r <= '0;
      cfg_top_r   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BLOCK_COUNT:  cfg_count_r <= cfg_wdata;
        CFG_REGION_START: cfg_start_r <= cfg_wdata;
        CFG_SCAN_TOP:     cfg_top_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Requests that are settled by the range checks alone never touch memory.
  always_comb begin
    direct     = 1'b1;
    direct_res = '{block_result: in_data.block_index, ref_count: '0, status: STAT_IGNORED};
    case (in_data.req_type)
      REQ_ALLOC: begin
        direct     = n_zero;
        direct_res = '{block_result: '0, ref_count: '0, status: STAT_NOFREE};
      end
      REQ_GET, REQ_INC: begin
        direct = !in_region;
      end
      REQ_FREE: begin
        if (in_data.block_index == '0) begin
          direct_res.status = STAT_IGNORED;
        end else if (!in_range) begin
          direct_res.status = STAT_RANGE;
        end else if (!in_region) begin
          direct_res.status = STAT_IGNORED;
        end else begin
          direct = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // Free-block search over the word read in the previous cycle.
  bra_find u_find (
    .word     (um_rdata),
    .limited  (chk_ptr_r == last_w),
    .lim      (last_bit),
    .from_top (cfg_top_r),
    .res      (fb)
  );

  assign scan_hit  = chk_vld_r && fb.found;
  assign scan_miss = chk_vld_r && !fb.found && (chk_ptr_r == scan_end_w);

  // New count for get, increment (saturating) and free (stops at zero).
  always_comb begin
    cnt_new = rc_rdata;
    case (req_r)
      REQ_INC:  cnt_new = (rc_rdata == REF_MAX) ? rc_rdata : rc_rdata + RC_W'(1);
      REQ_FREE: cnt_new = (rc_rdata == '0) ? rc_rdata : rc_rdata - RC_W'(1);
      default:  cnt_new = rc_rdata;
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (clr_r == BA_W'(MAX_BLOCKS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (direct) begin
            state_nxt = S_FINISH;
          end else if (in_data.req_type == REQ_ALLOC) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_UPD;
          end
        end
      end
      S_SCAN: begin
        if (scan_hit || scan_miss) begin
          state_nxt = S_FINISH;
        end
      end
      S_UPD: begin
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    clr_nxt       = clr_r;
    req_nxt       = req_r;
    blk_nxt       = blk_r;
    wptr_nxt      = wptr_r;
    iss_done_nxt  = iss_done_r;
    chk_vld_nxt   = 1'b0;
    chk_ptr_nxt   = chk_ptr_r;
    res_nxt       = res_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    rc_we         = 1'b0;
    rc_waddr      = blk_r;
    rc_wdata      = cnt_new;
    rc_raddr      = BA_W'(in_data.block_index);
    um_we         = 1'b0;
    um_waddr      = WA_W'(blk_r >> BIT_W);
    um_wdata      = um_rdata & ~(WORD_W'(1) << blk_r[BIT_W-1:0]);
    um_raddr      = WA_W'(in_data.block_index >> BIT_W);
    case (state_r)
      S_CLEAR: begin
        rc_we    = 1'b1;
        rc_waddr = clr_r;
        rc_wdata = '0;
        um_we    = 1'b1;
        um_waddr = WA_W'(clr_r >> BIT_W);
        um_wdata = '0;
        clr_nxt  = clr_r + BA_W'(1);
      end
      S_IDLE: begin
        if (accept) begin
          req_nxt      = in_data.req_type;
          blk_nxt      = BA_W'(in_data.block_index);
          res_nxt      = direct_res;
          wptr_nxt     = cfg_top_r ? last_w : '0;
          iss_done_nxt = 1'b0;
        end
      end
      S_SCAN: begin
        // Issue one word read per cycle while the search window lasts.
        um_raddr = wptr_r;
        if (!iss_done_r) begin
          chk_vld_nxt = 1'b1;
          chk_ptr_nxt = wptr_r;
          if (wptr_r == scan_end_w) begin
            iss_done_nxt = 1'b1;
          end else if (cfg_top_r) begin
            wptr_nxt = wptr_r - WA_W'(1);
          end else begin
            wptr_nxt = wptr_r + WA_W'(1);
          end
        end
        if (scan_hit) begin
          um_we    = 1'b1;
          um_waddr = chk_ptr_r;
          um_wdata = um_rdata | (WORD_W'(1) << fb.bit_pos);
          rc_we    = 1'b1;
          rc_waddr = BA_W'({chk_ptr_r, fb.bit_pos});
          rc_wdata = RC_W'(1);
          res_nxt  = '{block_result: BLK_W'({chk_ptr_r, fb.bit_pos}),
                       ref_count: RC_W'(1), status: STAT_OK};
        end else if (scan_miss) begin
          res_nxt = '{block_result: '0, ref_count: '0, status: STAT_NOFREE};
        end
      end
      S_UPD: begin
        rc_we   = (req_r != REQ_GET);
        // A free that brings the count to zero also releases the block.
        um_we   = (req_r == REQ_FREE) && (rc_rdata == RC_W'(1));
        res_nxt = '{block_result: BLK_W'(blk_r), ref_count: cnt_new, status: STAT_OK};
      end
      S_FINISH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      iss_done_r  <= 1'b0;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      iss_done_r  <= iss_done_nxt;
      chk_vld_r   <= chk_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    blk_r      <= blk_nxt;
    wptr_r     <= wptr_nxt;
    chk_ptr_r  <= chk_ptr_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  // Reference counts, one entry per block.
  bra_ram #(
    .WIDTH (RC_W),
    .DEPTH (MAX_BLOCKS),
    .AW    (BA_W)
  ) u_rc_ram (
    .clk   (clk),
    .we    (rc_we),
    .waddr (rc_waddr),
    .wdata (rc_wdata),
    .raddr (rc_raddr),
    .rdata (rc_rdata)
  );

  // Used map, 64 blocks per word.
  bra_ram #(
    .WIDTH (WORD_W),
    .DEPTH (WORDS),
    .AW    (WA_W)
  ) u_um_ram (
    .clk   (clk),
    .we    (um_we),
    .waddr (um_waddr),
    .wdata (um_wdata),
    .raddr (um_raddr),
    .rdata (um_rdata)
  );

  `include "block_refcount_allocator_defines.svh"

  `BRA_ASSERT_IMPLY(a_clear_writes, state_r == S_CLEAR, rc_we && um_we, "clearing pass skipped a write")
  `BRA_ASSERT_NEXT(a_one_at_a_time, accept, !in_ready, "second item taken while one is in work")
  `BRA_ASSERT_NEXT(a_finish_loads, (state_r == S_FINISH) && out_free, out_valid_r, "result not loaded into output register")
  `BRA_ASSERT_IMPLY(a_nofree_zero, out_valid_r && (out_data_r.status == STAT_NOFREE), (out_data_r.ref_count == '0) && (out_data_r.block_result == '0), "no-free result carries data")
  `BRA_ASSERT_IMPLY(a_idle_no_write, state_r == S_IDLE, !(rc_we || um_we), "memory written while idle")

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the block reference count allocator.
`timescale 1ns / 1ps

module tb_top;
  import bra_pkg::*;

  // The block is built with its default size; the shadow model below uses the same.
  localparam int NBLK = 4096;
  // Quiet cycles after draining; enough to outlast a full used-map search of any
  // request that is still in flight.
  localparam int SETTLE_CYCLES = 100;
  // Watchdog limit for a whole run, including the clearing pass.
  localparam int CYCLE_LIMIT = 1000000;
  // Register writes to this index must be dropped by the block.
  localparam logic [1:0] CFG_UNUSED_IDX = 2'd3;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_item_t   in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_item_t  out_data;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  block_refcount_allocator u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Requests waiting to be driven, and the replies that accepted requests still owe.
  in_item_t  req_backlog[$];
  out_item_t owed_replies[$];

  // Bookkeeping that tells the stimulus process when the block has gone quiet.
  // Each counter is written by one process only.
  int queued_total   = 0;
  int accepted_total = 0;
  int mismatches     = 0;
  int cycle_count    = 0;

  // Idle chances in percent per cycle; each hit starts an idle burst on that side.
  int send_idle_pct = 0;
  int take_idle_pct = 0;
  int send_gap = 0;
  int take_gap = 0;

  // Shadow copy of the allocator: used map, reference counts and registers.
  bit         block_taken [NBLK];
  logic [7:0] block_refs  [NBLK];
  int         cfg_blocks = NBLK;
  int         cfg_region = 0;
  bit         cfg_top    = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Computes the reply to one request and applies its side effects to the
  // shadow state. The block count is clamped to the device size, and a
  // count of zero leaves nothing to search or address.
  function automatic out_item_t predict_request(in_item_t req);
    out_item_t res;
    int span;
    int blk;
    int pick;
    int i;
    bit in_region;
    span = (cfg_blocks > NBLK) ? NBLK : cfg_blocks;
    blk = req.block_index;
    in_region = (blk >= cfg_region) && (blk < span);
    res.block_result = req.block_index;
    res.ref_count = '0;
    res.status = STAT_OK;
    case (req.req_type)
      REQ_ALLOC: begin
        // The address field plays no part in an allocation.
        pick = -1;
        for (i = 0; i < span && pick < 0; i++) begin
          if (cfg_top) begin
            if (!block_taken[span - 1 - i]) pick = span - 1 - i;
          end else if (!block_taken[i]) begin
            pick = i;
          end
        end
        if (pick < 0) begin
          res.block_result = '0;
          res.status = STAT_NOFREE;
        end else begin
          // The count starts at one even for a block below the data region.
          block_taken[pick] = 1'b1;
          block_refs[pick] = 8'd1;
          res.block_result = BLK_W'(pick);
          res.ref_count = 8'd1;
        end
      end
      REQ_GET, REQ_INC: begin
        if (!in_region) begin
          res.status = STAT_IGNORED;
        end else begin
          // Increments stop at the ceiling and never touch the used map.
          if (req.req_type == REQ_INC && block_refs[blk] < REF_MAX)
            block_refs[blk] = block_refs[blk] + 8'd1;
          res.ref_count = block_refs[blk];
        end
      end
      default: begin
        // Free: block zero is never released, blocks past the end are out of
        // range, and blocks below the data region are left alone.
        if (blk == 0) begin
          res.status = STAT_IGNORED;
        end else if (blk >= span) begin
          res.status = STAT_RANGE;
        end else if (blk < cfg_region) begin
          res.status = STAT_IGNORED;
        end else begin
          // A count that is already zero stays zero and the reply is still good.
          if (block_refs[blk] != 0) begin
            block_refs[blk] = block_refs[blk] - 8'd1;
            if (block_refs[blk] == 0) block_taken[blk] = 1'b0;
          end
          res.ref_count = block_refs[blk];
        end
      end
    endcase
    return res;
  endfunction

  // Request driver. Valid is raised without looking at ready and then held,
  // with the payload frozen, until the transfer takes place. Every accepted
  // request is predicted at the edge of its transfer, since the registers
  // only change while nothing is in flight.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        owed_replies.push_back(predict_request(in_data));
        accepted_total++;
      end
      if (!in_valid || in_ready) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (req_backlog.size() != 0 && $urandom_range(0, 99) < send_idle_pct) begin
          send_gap = $urandom_range(1, 12) - 1;
          in_valid <= 1'b0;
        end else if (req_backlog.size() != 0) begin
          in_data <= req_backlog.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Reply side back-pressure: ready drops in bursts so that a reply waits
  // in the output register while the next request is already being worked on.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (take_gap != 0) begin
      take_gap--;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 99) < take_idle_pct) begin
      take_gap = $urandom_range(1, 12) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Flags one field of a reply that differs from the prediction.
  task automatic report_field(string fname, logic [11:0] want, logic [11:0] seen);
    if (want !== seen) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, seen);
    end
  endtask

  // Reply monitor: every reply transfer is matched against the oldest owed reply.
  always @(posedge clk) begin : reply_monitor
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (owed_replies.size() == 0) begin
        mismatches++;
        $display("%0t: unrequested reply, expected none, actual block %0d count %0d status %0d",
                 $time, out_data.block_result, out_data.ref_count, out_data.status);
      end else begin
        want = owed_replies.pop_front();
        report_field("block_result", want.block_result, out_data.block_result);
        report_field("ref_count", 12'(want.ref_count), 12'(out_data.ref_count));
        report_field("status", 12'(want.status), 12'(out_data.status));
      end
    end
  end

  // Watchdog for a block that stops answering.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("block_refcount_allocator test failed");
      $finish;
    end
  end

  task automatic push_req(logic [1:0] kind, int idx);
    in_item_t it;
    it.req_type = kind;
    it.block_index = BLK_W'(idx);
    req_backlog.push_back(it);
    queued_total++;
  endtask

  // Queues a random mix of requests. Most addresses fall in a window just
  // above idx_base so that allocations, increments and frees keep meeting
  // the same blocks; one in ten is drawn from the whole address space.
  task automatic queue_mix(int count, int pct_alloc, int pct_inc, int pct_free,
                           int idx_base, int idx_span);
    int k;
    int roll;
    int idx;
    logic [1:0] kind;
    for (k = 0; k < count; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < pct_alloc) kind = REQ_ALLOC;
      else if (roll < pct_alloc + pct_inc) kind = REQ_INC;
      else if (roll < pct_alloc + pct_inc + pct_free) kind = REQ_FREE;
      else kind = REQ_GET;
      if ($urandom_range(0, 9) == 0) idx = $urandom_range(0, NBLK - 1);
      else idx = idx_base + $urandom_range(0, idx_span);
      push_req(kind, idx);
    end
  endtask

  // Waits until every queued request has made its transfer and every reply
  // has come back, then lets the block settle.
  task automatic wait_drained();
    while (accepted_total != queued_total || owed_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write per clock edge; the shadow copy follows at once,
  // masked to the register widths.
  task automatic write_reg(logic [1:0] idx, int value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_W'(value);
    case (idx)
      CFG_BLOCK_COUNT:  cfg_blocks = value & 32'h1FFF;
      CFG_REGION_START: cfg_region = value & 32'h1FFF;
      CFG_SCAN_TOP:     cfg_top = value[0];
      default: ;
    endcase
  endtask

  // Starts a new phase: drain, reprogram all three registers, pick the idling.
  task automatic start_phase(int blocks, int region, bit top, int send_pct, int take_pct);
    wait_drained();
    write_reg(CFG_BLOCK_COUNT, blocks);
    write_reg(CFG_REGION_START, region);
    write_reg(CFG_SCAN_TOP, top);
    @(posedge clk);
    cfg_we <= 1'b0;
    send_idle_pct = send_pct;
    take_idle_pct = take_pct;
  endtask

  initial begin
    foreach (block_taken[i]) begin
      block_taken[i] = 1'b0;
      block_refs[i] = '0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset settings: the basic life of a block,
    // freeing down to zero and past it, the never-freed block zero, and an
    // increment on a free block at the very top of the device.
    send_idle_pct = 10;
    take_idle_pct = 10;
    push_req(REQ_ALLOC, 0);
    push_req(REQ_ALLOC, 4095);
    push_req(REQ_GET, 1);
    push_req(REQ_INC, 1);
    push_req(REQ_FREE, 1);
    push_req(REQ_FREE, 1);
    push_req(REQ_FREE, 1);
    push_req(REQ_ALLOC, 0);
    push_req(REQ_FREE, 0);
    push_req(REQ_GET, 4095);
    push_req(REQ_INC, 4095);
    push_req(REQ_ALLOC, 0);
    push_req(REQ_FREE, 4095);

    // An oversized block count is clamped, the search runs from the top, and
    // blocks below the data region refuse get, increment and free. A write
    // to the unused register index must change nothing.
    start_phase(8191, 5, 1'b1, 0, 0);
    write_reg(CFG_UNUSED_IDX, 8191);
    @(posedge clk);
    cfg_we <= 1'b0;
    push_req(REQ_ALLOC, 7);
    push_req(REQ_GET, 2);
    push_req(REQ_INC, 2);
    push_req(REQ_FREE, 2);
    push_req(REQ_ALLOC, 0);
    push_req(REQ_FREE, 4095);

    // Two blocks, both taken: allocation finds nothing, and addresses past
    // the end give out of range on free and are ignored otherwise.
    start_phase(2, 0, 1'b0, 5, 5);
    push_req(REQ_ALLOC, 1);
    push_req(REQ_FREE, 3);
    push_req(REQ_FREE, 4095);
    push_req(REQ_GET, 2);
    push_req(REQ_INC, 4095);

    // Random part. Small devices keep the map close to full, so allocation
    // failures, reuse of freed blocks and both search directions all occur.
    start_phase(16, 4, 1'b0, 15, 15);
    queue_mix(230, 35, 20, 30, 0, 19);
    start_phase(16, 4, 1'b1, 10, 50);
    queue_mix(230, 35, 20, 30, 0, 19);
    start_phase(8191, 0, 1'b1, 20, 10);
    queue_mix(150, 30, 20, 30, 4040, 55);

    // Hammer a single block with increments so that its count saturates,
    // with no idling at all on either side.
    start_phase(3, 1, 1'b0, 0, 0);
    queue_mix(340, 3, 90, 3, 2, 0);

    // Data region beyond the end, where every get and increment is ignored, then devices of one block and of none.
    start_phase(64, 8191, 1'b1, 15, 15);
    queue_mix(60, 30, 25, 25, 0, 70);
    start_phase(1, 0, 1'b0, 15, 15);
    queue_mix(60, 30, 20, 30, 0, 3);
    start_phase(0, 0, 1'b0, 15, 15);
    queue_mix(30, 40, 20, 20, 0, 3);

    // Final stretch runs at full rate on both sides.
    start_phase(100, 40, 1'b0, 0, 0);
    queue_mix(230, 30, 25, 30, 30, 75);

    wait_drained();
    if (mismatches == 0) begin
      $display("block_refcount_allocator test passed");
    end else begin
      $display("block_refcount_allocator test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/bra_pkg.sv
rtl/bra_ram.sv
rtl/bra_find.sv
rtl/block_refcount_allocator.sv
tb/tb_top.sv
